// ----- design/dlt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta-list timer package
// Shared constants, codes and item types of the callout timer queue.
// ----------------------------------------------------------------------------
package dlt_pkg;

   // Default sizes of the table and of a stored delta
   localparam int TABLE_DEPTH_DEF = 32;
   localparam int DELAY_BITS_DEF  = 16;

   // Fixed field widths of the items
   localparam int DELAY_W   = 16;
   localparam int HANDLER_W = 8;
   localparam int ARG_W     = 32;
   localparam int HELD_W    = 6;

   // Operation codes of the func field
   localparam logic FUNC_TICK   = 1'b0;
   localparam logic FUNC_INSERT = 1'b1;

   typedef enum logic [1:0] {
      KIND_FIRED    = 2'd0,
      KIND_ACCEPT   = 2'd1,
      KIND_OVERFLOW = 2'd2,
      KIND_TICK     = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_T_READ,
      ST_T_DATA,
      ST_I_READ,
      ST_I_DATA,
      ST_S_READ,
      ST_S_WRITE,
      ST_I_NEW,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 func;
      logic [DELAY_W-1:0]   delay;
      logic [HANDLER_W-1:0] handler;
      logic [ARG_W-1:0]     argument;
      logic                 hold_fire;
   } req_type;

   typedef struct packed {
      kind_type             kind;
      logic [HANDLER_W-1:0] fired_handler;
      logic [ARG_W-1:0]     fired_argument;
      logic [HELD_W-1:0]    entries_held;
      logic                 last;
   } rsp_type;

endpackage

// ----- design/dlt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-pair RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module dlt_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/delta_list_callout_timer.sv -----
`timescale 1ns / 1ps
// Sequence: an insert walks past the entries that fire no later, then shifts the tail back
//   one slot at a time and writes the new entry; an insert into a full table gets overflow.
//   A tick reads entries from the head, decrementing, firing or stepping over them, and
//   holds while a result waits on rsp_stall.
// Throughput: one item at a time; req_stall stays high until the sequencer is idle again.
// Reset: synchronous; clears entry count, head pointer, sequencer, tick flag and output valid.
// ----------------------------------------------------------------------------
// Delta-list callout timer
// Sorted queue of pending callouts held as relative delays in a circular RAM.
// Table contents stay undefined after reset; there is no clearing pass.
// ----------------------------------------------------------------------------
module delta_list_callout_timer #(
   parameter int TABLE_DEPTH = dlt_pkg::TABLE_DEPTH_DEF,
   parameter int DELAY_BITS  = dlt_pkg::DELAY_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dlt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dlt_pkg::rsp_type rsp_data
);

   import dlt_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int WORD_W = DELAY_BITS + HANDLER_W + ARG_W;
   localparam int HND_LO = ARG_W;
   localparam int DLT_LO = ARG_W + HANDLER_W;

   // Map a position in the list to a RAM address
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                             input logic [IDX_W-1:0] pos);
      logic [IDX_W:0] sum;
      sum = {1'b0, head} + {1'b0, pos};
      if (sum >= (IDX_W + 1)'(TABLE_DEPTH)) begin
         sum = sum - (IDX_W + 1)'(TABLE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [DELAY_BITS-1:0] rem_ff, rem_in;
   logic [HANDLER_W-1:0] hnd_ff, hnd_in;
   logic [ARG_W-1:0]     arg_ff, arg_in;
   logic                 hold_ff, hold_in;
   logic                 dec_done_ff, dec_done_in;
   kind_type             kind_ff, kind_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [WORD_W-1:0]    wr_data;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [WORD_W-1:0]    rd_data;

   logic                 out_free;
   logic                 emit;
   rsp_type              emit_data;
   logic                 req_take;
   logic [DELAY_BITS-1:0] rd_delta;
   logic [CNT_W-1:0]     idx_m1;
   logic [CNT_W-1:0]     cnt_m1;
   logic [CNT_W-1:0]     pos_ext;

   dlt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rd_delta  = rd_data[DLT_LO +: DELAY_BITS];
   assign idx_m1    = idx_ff - CNT_W'(1);
   assign cnt_m1    = count_ff - CNT_W'(1);
   assign pos_ext   = CNT_W'(pos_ff);

   // Control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         dec_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         dec_done_ff  <= dec_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      rem_ff      <= rem_in;
      hnd_ff      <= hnd_in;
      arg_ff      <= arg_in;
      hold_ff     <= hold_in;
      kind_ff     <= kind_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Sequence the walk, shift and fire passes over the table
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      rem_in      = rem_ff;
      hnd_in      = hnd_ff;
      arg_in      = arg_ff;
      hold_in     = hold_ff;
      dec_done_in = dec_done_ff;
      kind_in     = kind_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = '0;
      emit        = 1'b0;
      emit_data   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               rem_in      = DELAY_BITS'(req_data.delay);
               hnd_in      = req_data.handler;
               arg_in      = req_data.argument;
               hold_in     = req_data.hold_fire;
               idx_in      = '0;
               dec_done_in = 1'b0;
               if (req_data.func == FUNC_INSERT) begin
                  if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                     kind_in  = KIND_OVERFLOW;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_I_READ;
                  end
               end else begin
                  state_in = ST_T_READ;
               end
            end
         end

         // Tick: visit leading entries from the head
         ST_T_READ: begin
            if (idx_ff == count_ff) begin
               kind_in  = KIND_TICK;
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = phys(head_ff, idx_ff[IDX_W-1:0]);
               state_in = ST_T_DATA;
            end
         end

         ST_T_DATA: begin
            if (!dec_done_ff && rd_delta != '0 &&
                (hold_ff || rd_delta != DELAY_BITS'(1))) begin
               // Decrement the first nonzero entry and keep it
               wr_en       = 1'b1;
               wr_addr     = phys(head_ff, idx_ff[IDX_W-1:0]);
               wr_data     = rd_data;
               wr_data[DLT_LO +: DELAY_BITS] = rd_delta - DELAY_BITS'(1);
               dec_done_in = 1'b1;
               if (hold_ff) begin
                  kind_in  = KIND_TICK;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_T_READ;
               end
            end else if (dec_done_ff && rd_delta != '0) begin
               kind_in  = KIND_TICK;
               state_in = ST_DONE;
            end else if (hold_ff) begin
               // Zero entry held back: step over it
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_T_READ;
            end else if (out_free) begin
               // Fire the head entry and drop it
               emit                     = 1'b1;
               emit_data.kind           = KIND_FIRED;
               emit_data.fired_handler  = rd_data[HND_LO +: HANDLER_W];
               emit_data.fired_argument = rd_data[ARG_W-1:0];
               emit_data.entries_held   = HELD_W'(cnt_m1);
               emit_data.last           = 1'b0;
               head_in                  = phys(head_ff, IDX_W'(1));
               count_in                 = cnt_m1;
               if (rd_delta != '0) begin
                  dec_done_in = 1'b1;
               end
               state_in = ST_T_READ;
            end
         end

         // Insert: walk while the entry's delta fits in what is left
         ST_I_READ: begin
            if (idx_ff == count_ff) begin
               pos_in   = idx_ff[IDX_W-1:0];
               state_in = ST_S_READ;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = phys(head_ff, idx_ff[IDX_W-1:0]);
               state_in = ST_I_DATA;
            end
         end

         ST_I_DATA: begin
            if (rd_delta <= rem_ff) begin
               rem_in   = rem_ff - rd_delta;
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_I_READ;
            end else begin
               pos_in   = idx_ff[IDX_W-1:0];
               idx_in   = count_ff;
               state_in = ST_S_READ;
            end
         end

         // Shift the tail back by one, from the end down to the slot
         ST_S_READ: begin
            if (idx_ff == pos_ext) begin
               state_in = ST_I_NEW;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = phys(head_ff, idx_m1[IDX_W-1:0]);
               state_in = ST_S_WRITE;
            end
         end

         ST_S_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, idx_ff[IDX_W-1:0]);
            wr_data = rd_data;
            if (idx_m1 == pos_ext) begin
               wr_data[DLT_LO +: DELAY_BITS] = rd_delta - rem_ff;
            end
            idx_in   = idx_m1;
            state_in = ST_S_READ;
         end

         ST_I_NEW: begin
            wr_en    = 1'b1;
            wr_addr  = phys(head_ff, pos_ff);
            wr_data  = {rem_ff, hnd_ff, arg_ff};
            count_in = count_ff + CNT_W'(1);
            kind_in  = KIND_ACCEPT;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (out_free) begin
               emit                   = 1'b1;
               emit_data.kind         = kind_ff;
               emit_data.entries_held = HELD_W'(count_ff);
               emit_data.last         = 1'b1;
               state_in               = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Load or drain the output register
      rsp_data_in = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_fire_drops: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_data.kind == KIND_FIRED) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("fired item did not remove an entry");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.func == FUNC_INSERT && count_ff == CNT_W'(TABLE_DEPTH))
      |=> (state_ff == ST_DONE && kind_ff == KIND_OVERFLOW))
      else $error("insert into full table not rejected");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !wr_en)
      else $error("table written while idle");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Callout timer queue testbench
// Drives ticks and callout inserts into the delta-list timer, predicts every
// fired callout, acknowledge and tick summary from a table kept alongside,
// and compares each result field by field while both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
   import dlt_pkg::*;

   localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
   localparam int DELAY_BITS  = DELAY_BITS_DEF;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE      = 4 * TABLE_DEPTH + 16;
   localparam int PHASE_ITEMS = 93;
   localparam int STEP_ROWS   = 17;
   localparam int REQ_W       = $bits(req_type);

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type result;
   } step_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Predicted callout table
   int                   callout_count = 0;
   logic [DELAY_W-1:0]   slot_delta    [TABLE_DEPTH];
   logic [HANDLER_W-1:0] slot_handler  [TABLE_DEPTH];
   logic [ARG_W-1:0]     slot_argument [TABLE_DEPTH];

   rsp_type      step_results [$];
   rsp_type      awaited_results [$];
   rsp_type      oldest;
   step_row_type directed_steps [STEP_ROWS];

   int cycle_count     = 0;
   int mismatches      = 0;
   int items_sent      = 0;
   int big_delays      = 0;
   int sender_idle_pct = 0;
   int stall_pct       = 0;

   delta_list_callout_timer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Count cycles and give up at the limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, awaited_results.size());
         $display("simulation failed");
         $finish;
      end
   end

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic rsp_type outcome(kind_type kind, logic [HANDLER_W-1:0] handler,
                                       logic [ARG_W-1:0] argument, int held, logic last);
      rsp_type r;
      r.kind           = kind;
      r.fired_handler  = handler;
      r.fired_argument = argument;
      r.entries_held   = held[HELD_W-1:0];
      r.last           = last;
      return r;
   endfunction

   function automatic rsp_type summary(kind_type kind, int held);
      return outcome(kind, '0, '0, held, 1'b1);
   endfunction

   function automatic req_type callout_item(logic [DELAY_W-1:0] delay,
                                            logic [HANDLER_W-1:0] handler,
                                            logic [ARG_W-1:0] argument, logic hold);
      req_type r;
      r.func      = FUNC_INSERT;
      r.delay     = delay;
      r.handler   = handler;
      r.argument  = argument;
      r.hold_fire = hold;
      return r;
   endfunction

   // Unused fields of a tick carry junk
   function automatic req_type tick_item(logic hold);
      req_type r;
      r.func      = FUNC_TICK;
      r.delay     = DELAY_W'($urandom);
      r.handler   = HANDLER_W'($urandom);
      r.argument  = $urandom;
      r.hold_fire = hold;
      return r;
   endfunction

   function automatic req_type random_callout(int delay);
      return callout_item(delay[DELAY_W-1:0], HANDLER_W'($urandom), $urandom,
                          1'($urandom_range(1)));
   endfunction

   // Apply one item to the predicted table and collect its results
   task automatic advance_timer_table(input req_type item);
      logic [DELAY_W-1:0] remaining;
      int pos;
      int fired;
      step_results.delete();
      if (item.func == FUNC_INSERT) begin
         if (callout_count >= TABLE_DEPTH) begin
            step_results.push_back(summary(KIND_OVERFLOW, callout_count));
         end else begin
            remaining = DELAY_W'(64'(item.delay) & ((64'd1 << DELAY_BITS) - 64'd1));
            pos = 0;
            // walk past every entry that fires no later
            while (pos < callout_count && slot_delta[pos] <= remaining) begin
               remaining = remaining - slot_delta[pos];
               pos++;
            end
            if (pos < callout_count) begin
               slot_delta[pos] = slot_delta[pos] - remaining;
            end
            for (int i = callout_count; i > pos; i--) begin
               slot_delta[i]    = slot_delta[i-1];
               slot_handler[i]  = slot_handler[i-1];
               slot_argument[i] = slot_argument[i-1];
            end
            slot_delta[pos]    = remaining;
            slot_handler[pos]  = item.handler;
            slot_argument[pos] = item.argument;
            callout_count++;
            step_results.push_back(summary(KIND_ACCEPT, callout_count));
         end
      end else begin
         // decrement the first nonzero delta
         pos = 0;
         while (pos < callout_count && slot_delta[pos] == 0) begin
            pos++;
         end
         if (pos < callout_count) begin
            slot_delta[pos] = slot_delta[pos] - 1'b1;
         end
         if (!item.hold_fire) begin
            fired = 0;
            while (fired < callout_count && slot_delta[fired] == 0) begin
               step_results.push_back(outcome(KIND_FIRED, slot_handler[fired],
                                              slot_argument[fired],
                                              callout_count - fired - 1, 1'b0));
               fired++;
            end
            for (int i = 0; i + fired < callout_count; i++) begin
               slot_delta[i]    = slot_delta[i+fired];
               slot_handler[i]  = slot_handler[i+fired];
               slot_argument[i] = slot_argument[i+fired];
            end
            callout_count = callout_count - fired;
         end
         step_results.push_back(summary(KIND_TICK, callout_count));
      end
   endtask

   // Offer one item, hold it until accepted, then record what it should cause
   task automatic send_item(input req_type item, input logic typed, input rsp_type result);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      advance_timer_table(item);
      if (typed) begin
         awaited_results.push_back(result);
      end else begin
         foreach (step_results[k]) awaited_results.push_back(step_results[k]);
      end
      items_sent++;
   endtask

   // Drop valid and hold off until every awaited result has come
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
   endtask

   // A few callouts with short delays, then enough ticks to fire them
   task automatic schedule_burst();
      int n;
      int span;
      int d;
      n = $urandom_range(6, 1);
      span = 0;
      repeat (n) begin
         d = $urandom_range(12);
         if (d > span) span = d;
         send_item(random_callout(d), 1'b0, '0);
      end
      repeat (span + 2) send_item(tick_item($urandom_range(9) == 0), 1'b0, '0);
   endtask

   // Fill the table, push past full, then tick most of it away
   task automatic fill_burst();
      while (callout_count < TABLE_DEPTH) begin
         send_item(random_callout($urandom_range(20)), 1'b0, '0);
      end
      repeat ($urandom_range(3, 1)) send_item(random_callout($urandom), 1'b0, '0);
      repeat (24) send_item(tick_item($urandom_range(7) == 0), 1'b0, '0);
   endtask

   // Any item at all; long delays are kept rare so the table keeps draining
   task automatic noise_item();
      req_type item;
      item = REQ_W'({$urandom, $urandom});
      if (item.func == FUNC_INSERT) begin
         if (big_delays < 4 && $urandom_range(15) == 0) begin
            big_delays++;
         end else begin
            item.delay = DELAY_W'($urandom_range(24));
         end
      end
      send_item(item, 1'b0, '0);
   endtask

   task automatic flag_mismatch(input string what);
      if (mismatches < 40) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
      mismatches++;
   endtask

   task automatic check_result(input rsp_type got);
      if (awaited_results.size() == 0) begin
         flag_mismatch($sformatf("result with nothing awaited: %p", got));
      end else begin
         oldest = awaited_results.pop_front();
         if (got.kind !== oldest.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", got.kind, oldest.kind));
         if (got.fired_handler !== oldest.fired_handler)
            flag_mismatch($sformatf("fired_handler %h, want %h",
                                    got.fired_handler, oldest.fired_handler));
         if (got.fired_argument !== oldest.fired_argument)
            flag_mismatch($sformatf("fired_argument %h, want %h",
                                    got.fired_argument, oldest.fired_argument));
         if (got.entries_held !== oldest.entries_held)
            flag_mismatch($sformatf("entries_held %0d, want %0d",
                                    got.entries_held, oldest.entries_held));
         if (got.last !== oldest.last)
            flag_mismatch($sformatf("last %b, want %b", got.last, oldest.last));
      end
   endtask

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         check_result(rsp_data);
      end
   end

   initial begin
      directed_steps = '{
         '{tick_item(1'b0), 1'b1, summary(KIND_TICK, 0)},
         '{tick_item(1'b1), 1'b1, summary(KIND_TICK, 0)},
         '{callout_item(16'h0000, 8'hFF, 32'hFFFF_FFFF, 1'b0), 1'b1, summary(KIND_ACCEPT, 1)},
         '{callout_item(16'h0000, 8'h00, 32'h0000_0000, 1'b0), 1'b1, summary(KIND_ACCEPT, 2)},
         '{tick_item(1'b1), 1'b1, summary(KIND_TICK, 2)},
         '{tick_item(1'b0), 1'b0, rsp_type'('0)},
         '{callout_item(16'h0003, 8'h01, 32'hA5A5_A5A5, 1'b1), 1'b1, summary(KIND_ACCEPT, 1)},
         '{callout_item(16'h0001, 8'h02, 32'h5A5A_5A5A, 1'b0), 1'b1, summary(KIND_ACCEPT, 2)},
         '{callout_item(16'h0003, 8'h03, 32'h1234_5678, 1'b0), 1'b1, summary(KIND_ACCEPT, 3)},
         '{tick_item(1'b0), 1'b0, rsp_type'('0)},
         '{tick_item(1'b1), 1'b1, summary(KIND_TICK, 2)},
         '{tick_item(1'b0), 1'b0, rsp_type'('0)},
         '{callout_item(16'hFFFF, 8'h80, 32'h8000_0000, 1'b0), 1'b1, summary(KIND_ACCEPT, 1)},
         '{callout_item(16'h8000, 8'h7F, 32'h7FFF_FFFF, 1'b0), 1'b1, summary(KIND_ACCEPT, 2)},
         '{callout_item(16'h0000, 8'h55, 32'h0000_FFFF, 1'b1), 1'b1, summary(KIND_ACCEPT, 3)},
         '{tick_item(1'b0), 1'b0, rsp_type'('0)},
         '{tick_item(1'b0), 1'b1, summary(KIND_TICK, 2)}
      };

      // Hold reset, then release it
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed steps, then a pause until all results are in
      foreach (directed_steps[n]) begin
         send_item(directed_steps[n].item, directed_steps[n].typed, directed_steps[n].result);
      end
      drain_results();

      // Random phases: free flow, slow sender, slow receiver, both mildly idle
      for (int ph = 0; ph < 4; ph++) begin
         int target;
         int pick;
         case (ph)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 87; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 87; end
            default: begin sender_idle_pct = 10; stall_pct = 10; end
         endcase
         target = items_sent + PHASE_ITEMS;
         if (ph == 0) fill_burst();
         while (items_sent < target) begin
            pick = $urandom_range(9);
            if (pick <= 4) begin
               schedule_burst();
            end else if (pick == 5 && $urandom_range(1) == 1) begin
               fill_burst();
            end else begin
               noise_item();
            end
         end
         drain_results();
      end

      // Let any stray result show up
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/dlt_pkg.sv
design/dlt_ram.sv
design/delta_list_callout_timer.sv
dv/tb.sv
